// ===== rtl/core/stm_pkg.sv =====
// Shared definitions for the sparse triplet merge adder.
// Holds the command codes and the sequencer state type; no dependencies.
package stm_pkg;

  // Command field of an input request
  localparam int CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RUN    = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } stm_state_t;

endpackage

// ===== rtl/core/stm_chan_if.sv =====
// Valid/ready channel interfaces for the sparse triplet merge adder.
// Depends on stm_pkg for the command width.
interface stm_in_if import stm_pkg::*; #(
  parameter int INDEX_BITS = 8,
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [CMD_BITS-1:0]          command;
  logic [INDEX_BITS-1:0]        row;
  logic [INDEX_BITS-1:0]        col;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface stm_out_if #(
  parameter int INDEX_BITS = 8,
  parameter int VALUE_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic [INDEX_BITS-1:0]      row_res;
  logic [INDEX_BITS-1:0]      col_res;
  logic signed [VALUE_BITS:0] value_res;
  logic                       last;

  modport source (output valid, row_res, col_res, value_res, last, input ready);
  modport sink   (input valid, row_res, col_res, value_res, last, output ready);
endinterface

// ===== rtl/core/stm_list_mem.sv =====
// Triplet list storage: one write port, one read port with registered data.
// No package dependencies.
module stm_list_mem #(
  parameter int DEPTH     = 32,
  parameter int WIDTH     = 48,
  parameter int ADDR_BITS = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/stm_merge_core.sv =====
// Load/merge sequencer: list fill counts, head pointers, key compare,
// value add and the result output register. Depends on stm_pkg.
module stm_merge_core import stm_pkg::*; #(
  parameter int LIST_DEPTH = 32,
  parameter int INDEX_BITS = 8,
  parameter int VALUE_BITS = 32,
  localparam int EntryBits = 2 * INDEX_BITS + VALUE_BITS,
  localparam int AddrBits  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CountBits = $clog2(LIST_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request side
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CMD_BITS-1:0]          in_command,
  input  logic [INDEX_BITS-1:0]        in_row,
  input  logic [INDEX_BITS-1:0]        in_col,
  input  logic signed [VALUE_BITS-1:0] in_value,
  // result side
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [INDEX_BITS-1:0]        out_row_res,
  output logic [INDEX_BITS-1:0]        out_col_res,
  output logic signed [VALUE_BITS:0]   out_value_res,
  output logic                         out_last,
  // list memories
  output logic                         wr_a,
  output logic                         wr_b,
  output logic [AddrBits-1:0]          waddr_a,
  output logic [AddrBits-1:0]          waddr_b,
  output logic [EntryBits-1:0]         wdata,
  output logic [AddrBits-1:0]          raddr_a,
  output logic [AddrBits-1:0]          raddr_b,
  input  logic [EntryBits-1:0]         rdata_a,
  input  logic [EntryBits-1:0]         rdata_b,
  // status
  output logic                         busy
);

  stm_state_t state_r, state_nxt;
  logic [CountBits-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CountBits-1:0] ia_r, ia_nxt, ib_r, ib_nxt, ia_adv, ib_adv;
  logic out_valid_r;
  logic [INDEX_BITS-1:0] row_res_r, col_res_r;
  logic signed [VALUE_BITS:0] value_res_r, val_a_ext, val_b_ext, val_sel;
  logic last_r;

  logic accept, a_left, b_left, take_a, take_b, step, done;
  logic [2*INDEX_BITS-1:0] key_a, key_b;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign busy     = (state_r == ST_MERGE);
  assign wdata    = {in_row, in_col, in_value};
  assign waddr_a  = cnt_a_r[AddrBits-1:0];
  assign waddr_b  = cnt_b_r[AddrBits-1:0];

  // Compare list heads on (row, col) and pick which head(s) to consume
  assign a_left = (ia_r < cnt_a_r);
  assign b_left = (ib_r < cnt_b_r);
  assign key_a  = rdata_a[EntryBits-1 -: 2*INDEX_BITS];
  assign key_b  = rdata_b[EntryBits-1 -: 2*INDEX_BITS];

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (!a_left) begin
      take_b = 1'b1;
    end else if (!b_left) begin
      take_a = 1'b1;
    end else if (key_a < key_b) begin
      take_a = 1'b1;
    end else if (key_a > key_b) begin
      take_b = 1'b1;
    end else begin
      take_a = 1'b1;
      take_b = 1'b1;
    end
  end

  // Sign-extend both head values and add; select by what is consumed
  assign val_a_ext = {rdata_a[VALUE_BITS-1], rdata_a[VALUE_BITS-1:0]};
  assign val_b_ext = {rdata_b[VALUE_BITS-1], rdata_b[VALUE_BITS-1:0]};

  always_comb begin
    if (take_a && take_b) begin
      val_sel = val_a_ext + val_b_ext;
    end else if (take_a) begin
      val_sel = val_a_ext;
    end else begin
      val_sel = val_b_ext;
    end
  end

  // Advance only when the output register can take a result
  assign step   = (state_r == ST_MERGE) && (!out_valid_r || out_ready);
  assign ia_adv = ia_r + CountBits'(take_a);
  assign ib_adv = ib_r + CountBits'(take_b);
  assign done   = (ia_adv >= cnt_a_r) && (ib_adv >= cnt_b_r);

  // Pointers feed the read address directly so next head arrives in time
  always_comb begin
    ia_nxt = ia_r;
    ib_nxt = ib_r;
    if (step) begin
      ia_nxt = done ? '0 : ia_adv;
      ib_nxt = done ? '0 : ib_adv;
    end
  end

  assign raddr_a = ia_nxt[AddrBits-1:0];
  assign raddr_b = ib_nxt[AddrBits-1:0];

  // Command decode and sequencing
  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_LOAD_A: begin
              if (cnt_a_r != CountBits'(LIST_DEPTH)) begin
                wr_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + CountBits'(1);
              end
            end
            CMD_LOAD_B: begin
              if (cnt_b_r != CountBits'(LIST_DEPTH)) begin
                wr_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + CountBits'(1);
              end
            end
            CMD_RUN: begin
              if ((cnt_a_r != '0) || (cnt_b_r != '0)) begin
                state_nxt = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (step && done) begin
          state_nxt = ST_IDLE;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (step) begin
      row_res_r   <= take_a ? rdata_a[EntryBits-1 -: INDEX_BITS]
                            : rdata_b[EntryBits-1 -: INDEX_BITS];
      col_res_r   <= take_a ? rdata_a[VALUE_BITS +: INDEX_BITS]
                            : rdata_b[VALUE_BITS +: INDEX_BITS];
      value_res_r <= val_sel;
      last_r      <= done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_res   = row_res_r;
  assign out_col_res   = col_res_r;
  assign out_value_res = value_res_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/core/sparse_triplet_merge_add.sv =====
// Sparse matrix adder on row-major coordinate triplet lists.
// Depends on stm_pkg, stm_chan_if, stm_list_mem and stm_merge_core.
//
// Usage:
// - in_ch carries requests: command 0 appends (row, col, value) to list A,
//   1 appends to list B, 2 runs the merge; code 3 is taken and ignored.
//   An append to a full list is dropped.
// - in_ch.ready stays high between runs, so appends are taken back to back.
// - A run walks both lists and emits one result triplet per cycle on out_ch
//   while the receiver is ready; equal positions are summed into one
//   (VALUE_BITS+1)-bit value, the final triplet carries last.
// - The first result is valid once the run request has moved the sequencer to
//   the merge state and the first step has loaded the output register (heads
//   are read while idle); in_ch.ready is low until the last step, one merge
//   step per cycle while the receiver is ready. A run on two empty lists returns
//   nothing. After a run both lists are empty.
// - A stall on out_ch freezes the merge; the pending result is held in the output
//   register, and new requests are taken while it waits once the run is finished.
// - Reset empties both lists (fill counts only, no clearing pass) and drops any
//   pending result.
module sparse_triplet_merge_add #(
  parameter int LIST_DEPTH = 32,
  parameter int INDEX_BITS = 8,
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  stm_in_if.sink     in_ch,
  stm_out_if.source  out_ch
);

  localparam int EntryBits = 2 * INDEX_BITS + VALUE_BITS;
  localparam int AddrBits  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                 wr_a, wr_b, busy;
  logic [AddrBits-1:0]  waddr_a, waddr_b, raddr_a, raddr_b;
  logic [EntryBits-1:0] wdata, rdata_a, rdata_b;

  // Sequencer
  stm_merge_core #(
    .LIST_DEPTH (LIST_DEPTH),
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_command    (in_ch.command),
    .in_row        (in_ch.row),
    .in_col        (in_ch.col),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_row_res   (out_ch.row_res),
    .out_col_res   (out_ch.col_res),
    .out_value_res (out_ch.value_res),
    .out_last      (out_ch.last),
    .wr_a          (wr_a),
    .wr_b          (wr_b),
    .waddr_a       (waddr_a),
    .waddr_b       (waddr_b),
    .wdata         (wdata),
    .raddr_a       (raddr_a),
    .raddr_b       (raddr_b),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .busy          (busy)
  );

  // List A storage
  stm_list_mem #(
    .DEPTH     (LIST_DEPTH),
    .WIDTH     (EntryBits),
    .ADDR_BITS (AddrBits)
  ) u_list_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr_a),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  // List B storage
  stm_list_mem #(
    .DEPTH     (LIST_DEPTH),
    .WIDTH     (EntryBits),
    .ADDR_BITS (AddrBits)
  ) u_list_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr_b),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Lists are never written while a merge walks them
  a_no_write_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(wr_a || wr_b))
    else $error("list write during merge");

  // One request writes at most one list
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_a && wr_b))
    else $error("both lists written at once");

  // A finished merge leaves its final result marked last
  a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_ch.valid && out_ch.last))
    else $error("merge ended without a last result");

endmodule

// ===== tb/sparse_triplet_merge_add_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sparse_triplet_merge_add: loads triplet lists, mostly
// sorted, runs merges and checks every result. Depends on stm_pkg and stm_chan_if.
module sparse_triplet_merge_add_test;
  import stm_pkg::*;

  localparam int LIST_DEPTH  = 32;
  localparam int INDEX_BITS  = 8;
  localparam int VALUE_BITS  = 32;
  localparam int ITEMS       = 320;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;
  localparam int N_DIR       = 26;
  localparam int MAX_SHOWN   = 10;

  // Code 3 is taken by the block and ignored
  localparam logic [CMD_BITS-1:0] CMD_IGNORED = 2'd3;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        row;
    logic [INDEX_BITS-1:0]        col;
    logic signed [VALUE_BITS-1:0] value;
  } triplet_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]      row;
    logic [INDEX_BITS-1:0]      col;
    logic signed [VALUE_BITS:0] sum;
    logic                       last;
  } sum_triplet_t;

  // exp_n: -1 take the predictor, 0 no result, 1 the one result typed in
  typedef struct {
    logic [CMD_BITS-1:0]          cmd;
    logic [INDEX_BITS-1:0]        row;
    logic [INDEX_BITS-1:0]        col;
    logic signed [VALUE_BITS-1:0] value;
    int                           exp_n;
    sum_triplet_t                 exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  stm_in_if  #(.INDEX_BITS(INDEX_BITS), .VALUE_BITS(VALUE_BITS)) req_if ();
  stm_out_if #(.INDEX_BITS(INDEX_BITS), .VALUE_BITS(VALUE_BITS)) res_if ();

  sparse_triplet_merge_add #(
    .LIST_DEPTH(LIST_DEPTH),
    .INDEX_BITS(INDEX_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  always #10 clk = ~clk;

  // Predictor copy of the two lists
  triplet_t     list_a [LIST_DEPTH];
  triplet_t     list_b [LIST_DEPTH];
  int           fill_a = 0;
  int           fill_b = 0;
  sum_triplet_t sum_triplets_due [$];

  int  send_idle_pct = 27;
  int  recv_idle_pct = 82;
  bit  hold_go = 1'b0;
  int  items_sent = 0;
  int  runs_sent = 0;
  int  triplets_seen = 0;
  int  summed_count = 0;
  int  mismatches = 0;
  int  stall_count = 0;

  dir_row_t dir_tbl [N_DIR] = '{
    // run on empty lists, ignored code with all bits set
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, 0, '0},
    '{CMD_IGNORED, 8'hff, 8'hff, 32'shffff_ffff, 0, '0},
    // largest positive sum
    '{CMD_LOAD_A,  8'h00, 8'h00, 32'sh7fff_ffff, -1, '0},
    '{CMD_LOAD_B,  8'h00, 8'h00, 32'sh7fff_ffff, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, 1,
      '{8'h00, 8'h00, 33'sh0_ffff_fffe, 1'b1}},
    // most negative sum at the far corner
    '{CMD_LOAD_A,  8'hff, 8'hff, 32'sh8000_0000, -1, '0},
    '{CMD_LOAD_B,  8'hff, 8'hff, 32'sh8000_0000, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, 1,
      '{8'hff, 8'hff, 33'sh1_0000_0000, 1'b1}},
    // zero sum is kept
    '{CMD_LOAD_A,  8'h01, 8'h02, 32'sh0000_0005, -1, '0},
    '{CMD_LOAD_B,  8'h01, 8'h02, 32'shffff_fffb, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, 1,
      '{8'h01, 8'h02, 33'sh0_0000_0000, 1'b1}},
    // list B alone
    '{CMD_LOAD_B,  8'h07, 8'h07, 32'shffff_ffff, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, 1,
      '{8'h07, 8'h07, 33'sh1_ffff_ffff, 1'b1}},
    // row beats column in the order test
    '{CMD_LOAD_A,  8'h00, 8'hff, 32'sh0000_0001, -1, '0},
    '{CMD_LOAD_A,  8'h01, 8'h00, 32'sh0000_0002, -1, '0},
    '{CMD_LOAD_B,  8'h00, 8'hc8, 32'sh0000_0003, -1, '0},
    '{CMD_LOAD_B,  8'h01, 8'h00, 32'sh0000_0004, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, -1, '0},
    // unsorted list A, only the heads are compared
    '{CMD_LOAD_A,  8'h05, 8'h05, 32'sh0000_0001, -1, '0},
    '{CMD_LOAD_A,  8'h02, 8'h02, 32'sh0000_0002, -1, '0},
    '{CMD_LOAD_B,  8'h03, 8'h03, 32'sh0000_0003, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, -1, '0},
    // duplicate position inside list A
    '{CMD_LOAD_A,  8'h04, 8'h04, 32'sh0000_0009, -1, '0},
    '{CMD_LOAD_A,  8'h04, 8'h04, 32'sh0000_000a, -1, '0},
    '{CMD_LOAD_B,  8'h04, 8'h04, 32'sh0000_0001, -1, '0},
    '{CMD_RUN,     8'h00, 8'h00, 32'sh0000_0000, -1, '0}
  };

  // Append to a list or merge both lists; keep=0 updates state only
  task automatic apply_to_lists(input logic [CMD_BITS-1:0] cmd, input triplet_t t,
                                input bit keep);
    int           ia;
    int           ib;
    sum_triplet_t r;
    logic [15:0]  key_a;
    logic [15:0]  key_b;
    ia = 0;
    ib = 0;
    case (cmd)
      CMD_LOAD_A: begin
        if (fill_a < LIST_DEPTH) begin
          list_a[fill_a] = t;
          fill_a++;
        end
      end
      CMD_LOAD_B: begin
        if (fill_b < LIST_DEPTH) begin
          list_b[fill_b] = t;
          fill_b++;
        end
      end
      CMD_RUN: begin
        while (ia < fill_a || ib < fill_b) begin
          key_a = {list_a[ia].row, list_a[ia].col};
          key_b = {list_b[ib].row, list_b[ib].col};
          if (ia >= fill_a || (ib < fill_b && key_b < key_a)) begin
            r.row = list_b[ib].row;
            r.col = list_b[ib].col;
            r.sum = {list_b[ib].value[VALUE_BITS-1], list_b[ib].value};
            ib++;
          end else if (ib >= fill_b || key_a < key_b) begin
            r.row = list_a[ia].row;
            r.col = list_a[ia].col;
            r.sum = {list_a[ia].value[VALUE_BITS-1], list_a[ia].value};
            ia++;
          end else begin
            r.row = list_a[ia].row;
            r.col = list_a[ia].col;
            r.sum = {list_a[ia].value[VALUE_BITS-1], list_a[ia].value}
                  + {list_b[ib].value[VALUE_BITS-1], list_b[ib].value};
            ia++;
            ib++;
            summed_count++;
          end
          r.last = (ia >= fill_a && ib >= fill_b);
          if (keep) sum_triplets_due.push_back(r);
        end
        fill_a = 0;
        fill_b = 0;
      end
      default: ;
    endcase
  endtask

  // Offer one request, idle at random first, and predict once it is taken
  task automatic send_req(input logic [CMD_BITS-1:0] cmd, input logic [INDEX_BITS-1:0] row,
                          input logic [INDEX_BITS-1:0] col,
                          input logic signed [VALUE_BITS-1:0] value,
                          input int exp_n = -1, input sum_triplet_t typed = '0);
    triplet_t t;
    t.row   = row;
    t.col   = col;
    t.value = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.row     <= row;
    req_if.col     <= col;
    req_if.value   <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_RUN) runs_sent++;
    apply_to_lists(cmd, t, exp_n < 0);
    if (exp_n == 1) sum_triplets_due.push_back(typed);
  endtask

  // Load a sorted pair of lists, list A reversed if reverse_a, and run them.
  // overlap: 0 random mix, 1 every position in both lists, 2 alternate A and B
  task automatic load_and_run(input int n_pos, input bit wide, input int overlap,
                              input bit reverse_a);
    triplet_t ta [$];
    triplet_t tb [$];
    triplet_t t;
    int       keys [$];
    int       sel;
    int       base_r;
    int       base_c;
    base_r = $urandom_range(0, 255);
    base_c = $urandom_range(0, 255);
    for (int i = 0; i < n_pos; i++) begin
      if (wide) keys.push_back($urandom_range(0, 16'hffff));
      else keys.push_back((((base_r + $urandom_range(0, 2)) % 256) << 8)
                          | ((base_c + $urandom_range(0, 2)) % 256));
    end
    keys.sort();
    for (int i = 0; i < keys.size(); i++) begin
      t.row   = 8'(keys[i] >> 8);
      t.col   = 8'(keys[i]);
      t.value = $urandom;
      if (overlap == 1) sel = 2;
      else if (overlap == 2) sel = i % 2;
      else sel = $urandom_range(0, 3);
      case (sel)
        0: ta.push_back(t);
        1: tb.push_back(t);
        default: begin
          ta.push_back(t);
          if ($urandom_range(0, 7) == 0) t.value = -t.value;
          else t.value = $urandom;
          tb.push_back(t);
        end
      endcase
    end
    if (reverse_a) ta.reverse();
    // Interleave the two load streams, with the odd ignored code
    while (ta.size() != 0 || tb.size() != 0) begin
      if ($urandom_range(0, 11) == 0)
        send_req(CMD_IGNORED, INDEX_BITS'($urandom), INDEX_BITS'($urandom), $urandom);
      if (tb.size() == 0 || (ta.size() != 0 && $urandom_range(0, 1) == 1)) begin
        t = ta.pop_front();
        send_req(CMD_LOAD_A, t.row, t.col, t.value);
      end else begin
        t = tb.pop_front();
        send_req(CMD_LOAD_B, t.row, t.col, t.value);
      end
    end
    send_req(CMD_RUN, INDEX_BITS'($urandom), INDEX_BITS'($urandom), $urandom);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check each result against the oldest expected triplet
  always @(posedge clk) begin
    sum_triplet_t e;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready) begin
      triplets_seen++;
      if (sum_triplets_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: row %0d col %0d sum %0d last %0b",
                   res_if.row_res, res_if.col_res, res_if.value_res, res_if.last);
      end else begin
        e = sum_triplets_due.pop_front();
        if (res_if.row_res !== e.row || res_if.col_res !== e.col
            || res_if.value_res !== e.sum || res_if.last !== e.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display({"mismatch: expected row %0d col %0d sum %0d last %0b,",
                      " got row %0d col %0d sum %0d last %0b"},
                     e.row, e.col, e.sum, e.last,
                     res_if.row_res, res_if.col_res, res_if.value_res, res_if.last);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid === 1'b1 && res_if.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int  mode;
    bit  wide_done;
    bit  press_done;
    wide_done  = 1'b0;
    press_done = 1'b0;
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_LOAD_A;
    req_if.row     <= '0;
    req_if.col     <= '0;
    req_if.value   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < N_DIR; i++)
      send_req(dir_tbl[i].cmd, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].value,
               dir_tbl[i].exp_n, dir_tbl[i].exp);

    // Random sets in three idling phases
    while (items_sent < ITEMS) begin
      if (items_sent < 130) begin
        send_idle_pct = 27;
        recv_idle_pct = 82;
      end else if (items_sent < 230) begin
        send_idle_pct = 82;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!wide_done && items_sent >= 130) begin
        // Both lists overfill with disjoint positions: the longest run
        wide_done = 1'b1;
        load_and_run(70, 1'b1, 2, 1'b0);
      end else if (!press_done && items_sent >= 230) begin
        // Hold the receiver off while both full lists merge
        press_done = 1'b1;
        hold_go = 1'b1;
        load_and_run(40, 1'b1, 1, 1'b0);
        // Keep offering appends so the input stalls behind the held merge
        repeat (4)
          send_req(CMD_LOAD_A, INDEX_BITS'($urandom), INDEX_BITS'($urandom), $urandom);
      end else begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          repeat ($urandom_range(2, 5))
            send_req(CMD_BITS'($urandom_range(0, 3)), INDEX_BITS'($urandom),
                     INDEX_BITS'($urandom), $urandom);
        end else begin
          load_and_run($urandom_range(0, 8), $urandom_range(0, 1), 0, mode == 1);
        end
      end
    end

    // Drain and let the tail settle
    req_if.valid <= 1'b0;
    while (sum_triplets_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += sum_triplets_due.size();

    $display("covered %0d requests and %0d merge runs under three stall mixes",
             items_sent, runs_sent);
    $display("checked %0d result triplets, %0d of them summed, %0d mismatches",
             triplets_seen, summed_count, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stm_pkg.sv
rtl/core/stm_chan_if.sv
rtl/core/stm_list_mem.sv
rtl/core/stm_merge_core.sv
rtl/core/sparse_triplet_merge_add.sv
tb/sparse_triplet_merge_add_test.sv
